### hdl/hfp_pkg.sv
// ----------------------------------------------------------------------------
// HMM forward probability package
// Shared sizes, codes and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hfp_pkg;

  // Model size.
  localparam int NUM_STATES  = 4;
  localparam int NUM_SYMBOLS = 4;

  // Fixed port widths.
  localparam int ACTION_W = 2;
  localparam int IDX_W    = 4;
  localparam int PROB_W   = 32;

  // Derived widths and depths.
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int TRANS_DEPTH = NUM_STATES * NUM_STATES;
  localparam int EMIT_DEPTH  = NUM_STATES * NUM_SYMBOLS;
  localparam int TRANS_AW    = $clog2(TRANS_DEPTH);
  localparam int EMIT_AW     = $clog2(EMIT_DEPTH);
  localparam int CMP_W       = IDX_W + 1;

  // 1.0 in unsigned Q1.31.
  localparam logic [PROB_W-1:0] Q_ONE = 32'h8000_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_INIT  = 2'd0,
    ACT_LOAD_TRANS = 2'd1,
    ACT_LOAD_EMIT  = 2'd2,
    ACT_OBSERVE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic               load_en;   // table load transfer this cycle
    logic               obs_en;    // observe transfer this cycle
    logic               issue;     // one product enters the pipeline
    logic               sel_init;  // product is the initial probability
    logic               first;     // first product of a destination row
    logic               last;      // last product of a destination row
    logic [STATE_W-1:0] src;       // source state, or state being emitted
    logic [STATE_W-1:0] dst;       // destination state
    logic               flip;      // new alpha vector becomes current
    logic               out_load;  // load the output register
    logic               out_last;  // result being loaded ends the vector
  } hfp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } hfp_sts_t;

endpackage

### hdl/hfp_ctrl.sv
// ----------------------------------------------------------------------------
// HMM forward probability controller
// Sequences loads, the per-symbol product walk, the drain and the emission.
// ----------------------------------------------------------------------------
module hfp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hfp_pkg::ACTION_W-1:0]  action_i,
  input  logic                          seq_start_i,
  input  logic                          seq_end_i,
  input  hfp_pkg::hfp_sts_t             sts_i,
  output hfp_pkg::hfp_cmd_t             cmd_o
);

  hfp_pkg::ctrl_state_e state_q, state_d;
  logic [hfp_pkg::STATE_W-1:0] i_q, i_d, j_q, j_d;
  logic start_q, start_d, end_q, end_d;
  logic accept, is_obs, last_i, last_j, issue_done, emit_step, emit_done;

  assign in_ready_o = (state_q == hfp_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_obs     = (hfp_pkg::action_e'(action_i) == hfp_pkg::ACT_OBSERVE);
  assign last_i     = (i_q == hfp_pkg::STATE_W'(hfp_pkg::NUM_STATES - 1));
  assign last_j     = (j_q == hfp_pkg::STATE_W'(hfp_pkg::NUM_STATES - 1));
  assign issue_done = last_j && (start_q || last_i);
  assign emit_step  = sts_i.out_free;
  assign emit_done  = emit_step && last_j;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hfp_pkg::ST_IDLE: begin
        if (accept && is_obs) state_d = hfp_pkg::ST_ISSUE;
      end
      hfp_pkg::ST_ISSUE: begin
        if (issue_done) state_d = hfp_pkg::ST_DRAIN;
      end
      hfp_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = end_q ? hfp_pkg::ST_EMIT : hfp_pkg::ST_IDLE;
      end
      hfp_pkg::ST_EMIT: begin
        if (emit_done) state_d = hfp_pkg::ST_IDLE;
      end
      default: state_d = hfp_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      hfp_pkg::ST_IDLE: begin
        cmd_o.load_en = accept && !is_obs;
        cmd_o.obs_en  = accept && is_obs;
      end
      hfp_pkg::ST_ISSUE: begin
        cmd_o.issue    = 1'b1;
        cmd_o.sel_init = start_q;
        cmd_o.src      = start_q ? j_q : i_q;
        cmd_o.dst      = j_q;
        cmd_o.first    = start_q || (i_q == '0);
        cmd_o.last     = start_q || last_i;
      end
      hfp_pkg::ST_DRAIN: begin
        cmd_o.flip = !sts_i.pipe_busy;
      end
      hfp_pkg::ST_EMIT: begin
        cmd_o.src      = j_q;
        cmd_o.out_load = emit_step;
        cmd_o.out_last = last_j;
      end
      default: cmd_o = '0;
    endcase
  end

  // Counters and captured sequence flags.
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    start_d = start_q;
    end_d   = end_q;
    case (state_q)
      hfp_pkg::ST_IDLE: begin
        if (accept && is_obs) begin
          start_d = seq_start_i;
          end_d   = seq_end_i;
          i_d     = '0;
          j_d     = '0;
        end
      end
      hfp_pkg::ST_ISSUE: begin
        if (issue_done) begin
          i_d = '0;
          j_d = '0;
        end else if (start_q || last_i) begin
          i_d = '0;
          j_d = j_q + 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      hfp_pkg::ST_EMIT: begin
        if (emit_done) j_d = '0;
        else if (emit_step) j_d = j_q + 1'b1;
      end
      default: begin
        i_d = i_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfp_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      start_q <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

endmodule

### hdl/hfp_dp.sv
// ----------------------------------------------------------------------------
// HMM forward probability datapath
// Probability tables, the product/accumulate pipeline, the two alpha banks
// and the output register.
// ----------------------------------------------------------------------------
module hfp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hfp_pkg::ACTION_W-1:0]  action_i,
  input  logic [hfp_pkg::IDX_W-1:0]     row_index_i,
  input  logic [hfp_pkg::IDX_W-1:0]     col_index_i,
  input  logic [hfp_pkg::PROB_W-1:0]    prob_value_i,
  input  logic [hfp_pkg::IDX_W-1:0]     obs_symbol_i,
  input  hfp_pkg::hfp_cmd_t             cmd_i,
  output hfp_pkg::hfp_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hfp_pkg::IDX_W-1:0]     state_index_o,
  output logic [hfp_pkg::PROB_W-1:0]    alpha_value_o,
  output logic                          last_o
);

  localparam int PW = hfp_pkg::PROB_W;
  localparam int SW = hfp_pkg::STATE_W;

  function automatic logic [PW-1:0] q_mul(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [2*PW-1:0] full;
    full = (2*PW)'(a) * (2*PW)'(b);
    return full[2*PW-2:PW-1];
  endfunction

  // Tables.
  logic [PW-1:0] init_mem  [hfp_pkg::NUM_STATES];
  logic [PW-1:0] trans_mem [hfp_pkg::TRANS_DEPTH];
  logic [PW-1:0] emit_mem  [hfp_pkg::EMIT_DEPTH];

  logic [PW-1:0] load_val;
  logic row_ok, col_st_ok, col_sym_ok, sym_in_ok;
  logic [hfp_pkg::TRANS_AW-1:0] trans_waddr, trans_raddr;
  logic [hfp_pkg::EMIT_AW-1:0]  emit_waddr, emit_raddr;

  // Observed symbol, forced to zero when out of range.
  logic [hfp_pkg::SYM_W-1:0] sym_q;
  logic                      sym_ok_q;

  // Alpha banks: bank_q is the current vector, the other one is being built.
  logic [PW-1:0] alpha_q [2][hfp_pkg::NUM_STATES];
  logic          bank_q;
  logic [PW-1:0] alpha_rd;

  // Pipeline registers.
  logic          v1_q, v2_q, v3_q;
  logic          sel1_q, first1_q, last1_q, first2_q, last2_q;
  logic [SW-1:0] dst1_q, dst2_q, dst3_q;
  logic [PW-1:0] init_rd_q, trans_rd_q, emit_rd_q, alpha_rd_q;
  logic [PW-1:0] emit2_q, emit3_q, prod_q, acc_q;
  logic [PW-1:0] prod_d, acc_d, emit_eff;
  logic [PW:0]   acc_sum;

  // Output register.
  logic                      out_valid_q;
  logic [hfp_pkg::IDX_W-1:0] state_index_q;
  logic [PW-1:0]             alpha_value_q;
  logic                      last_q;

  assign load_val   = (prob_value_i > hfp_pkg::Q_ONE) ? hfp_pkg::Q_ONE : prob_value_i;
  assign row_ok     = {1'b0, row_index_i} < hfp_pkg::CMP_W'(hfp_pkg::NUM_STATES);
  assign col_st_ok  = {1'b0, col_index_i} < hfp_pkg::CMP_W'(hfp_pkg::NUM_STATES);
  assign col_sym_ok = {1'b0, col_index_i} < hfp_pkg::CMP_W'(hfp_pkg::NUM_SYMBOLS);
  assign sym_in_ok  = {1'b0, obs_symbol_i} < hfp_pkg::CMP_W'(hfp_pkg::NUM_SYMBOLS);

  assign trans_waddr = hfp_pkg::TRANS_AW'(row_index_i[SW-1:0])
                     * hfp_pkg::TRANS_AW'(hfp_pkg::NUM_STATES)
                     + hfp_pkg::TRANS_AW'(col_index_i[SW-1:0]);
  assign emit_waddr  = hfp_pkg::EMIT_AW'(row_index_i[SW-1:0])
                     * hfp_pkg::EMIT_AW'(hfp_pkg::NUM_SYMBOLS)
                     + hfp_pkg::EMIT_AW'(col_index_i[hfp_pkg::SYM_W-1:0]);
  assign trans_raddr = hfp_pkg::TRANS_AW'(cmd_i.src)
                     * hfp_pkg::TRANS_AW'(hfp_pkg::NUM_STATES)
                     + hfp_pkg::TRANS_AW'(cmd_i.dst);
  assign emit_raddr  = hfp_pkg::EMIT_AW'(cmd_i.dst)
                     * hfp_pkg::EMIT_AW'(hfp_pkg::NUM_SYMBOLS)
                     + hfp_pkg::EMIT_AW'(sym_q);

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      case (hfp_pkg::action_e'(action_i))
        hfp_pkg::ACT_LOAD_INIT: begin
          if (row_ok) init_mem[row_index_i[SW-1:0]] <= load_val;
        end
        hfp_pkg::ACT_LOAD_TRANS: begin
          if (row_ok && col_st_ok) trans_mem[trans_waddr] <= load_val;
        end
        hfp_pkg::ACT_LOAD_EMIT: begin
          if (row_ok && col_sym_ok) emit_mem[emit_waddr] <= load_val;
        end
        default: begin
        end
      endcase
    end
  end

  // Table reads, registered.
  always_ff @(posedge clk_i) begin
    init_rd_q  <= init_mem[cmd_i.src];
    trans_rd_q <= trans_mem[trans_raddr];
    emit_rd_q  <= emit_mem[emit_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.obs_en) begin
      sym_q    <= sym_in_ok ? obs_symbol_i[hfp_pkg::SYM_W-1:0] : '0;
      sym_ok_q <= sym_in_ok;
    end
  end

  assign alpha_rd = alpha_q[bank_q][cmd_i.src];

  // Stage 2 multiplies, stage 3 accumulates with saturation at 1.0.
  assign prod_d   = sel1_q ? init_rd_q : q_mul(alpha_rd_q, trans_rd_q);
  assign acc_sum  = {1'b0, acc_q} + {1'b0, prod_q};
  assign acc_d    = first2_q ? prod_q
                  : ((acc_sum > {1'b0, hfp_pkg::Q_ONE}) ? hfp_pkg::Q_ONE : acc_sum[PW-1:0]);
  assign emit_eff = sym_ok_q ? emit3_q : '0;

  always_ff @(posedge clk_i) begin
    alpha_rd_q <= alpha_rd;
    sel1_q     <= cmd_i.sel_init;
    first1_q   <= cmd_i.first;
    last1_q    <= cmd_i.last;
    dst1_q     <= cmd_i.dst;
    prod_q     <= prod_d;
    emit2_q    <= emit_rd_q;
    first2_q   <= first1_q;
    last2_q    <= last1_q;
    dst2_q     <= dst1_q;
    emit3_q    <= emit2_q;
    dst3_q     <= dst2_q;
    if (v2_q) acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q && last2_q;
    end
  end

  // Finished rows are scaled by the emission probability into the spare bank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int s = 0; s < hfp_pkg::NUM_STATES; s++) begin
          alpha_q[b][s] <= '0;
        end
      end
    end else begin
      if (v3_q) alpha_q[~bank_q][dst3_q] <= q_mul(acc_q, emit_eff);
      if (cmd_i.flip) bank_q <= ~bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      state_index_q <= hfp_pkg::IDX_W'(cmd_i.src);
      alpha_value_q <= alpha_rd;
      last_q        <= cmd_i.out_last;
    end
  end

  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign state_index_o = state_index_q;
  assign alpha_value_o = alpha_value_q;
  assign last_o        = last_q;

endmodule

### hdl/hmm_forward_probability.sv
// ----------------------------------------------------------------------------
// HMM forward probability
// Forward pass of a hidden Markov model in unsigned Q1.31 fixed point.
// ----------------------------------------------------------------------------
// Load items write one entry of the initial, transition or emission table
// without holding up the input; values above 1.0 are stored as 1.0 and loads
// with an index beyond the table are dropped. An observe item that starts a
// sequence sets each alpha to its initial probability times its emission
// probability, issuing one product per state and then draining the pipeline.
// Any other observe item walks all NUM_STATES * NUM_STATES transition products
// through one shared multiplier and a saturating accumulator, one product per
// cycle. When an observe item ends a sequence, the alpha vector follows as
// NUM_STATES result transfers, state 0 first, the last one flagged by last_o;
// one result leaves per cycle while the output side keeps ready high. No
// further item is taken until the pipeline has drained and any alpha vector
// has been loaded into the output register. Products truncate, and sums
// saturate at 1.0 (0x8000_0000). The alpha vector is all zero after reset;
// table entries read before they were written give unspecified results.
// ----------------------------------------------------------------------------
module hmm_forward_probability (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hfp_pkg::ACTION_W-1:0]  action_i,
  input  logic [hfp_pkg::IDX_W-1:0]     row_index_i,
  input  logic [hfp_pkg::IDX_W-1:0]     col_index_i,
  input  logic [hfp_pkg::PROB_W-1:0]    prob_value_i,
  input  logic [hfp_pkg::IDX_W-1:0]     obs_symbol_i,
  input  logic                          seq_start_i,
  input  logic                          seq_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hfp_pkg::IDX_W-1:0]     state_index_o,
  output logic [hfp_pkg::PROB_W-1:0]    alpha_value_o,
  output logic                          last_o
);

  // The controller takes one input transfer at a time and drives the
  // datapath with one command word per cycle.
  hfp_pkg::hfp_cmd_t cmd;
  hfp_pkg::hfp_sts_t sts;

  hfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .seq_start_i (seq_start_i),
    .seq_end_i   (seq_end_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the tables, the product pipeline, both alpha banks
  // and the output register that parts the result side from the control.
  hfp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .prob_value_i  (prob_value_i),
    .obs_symbol_i  (obs_symbol_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .state_index_o (state_index_o),
    .alpha_value_o (alpha_value_o),
    .last_o        (last_o)
  );

endmodule

### hdl/hfp_checker.sv
// ----------------------------------------------------------------------------
// HMM forward probability checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module hfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [hfp_pkg::ACTION_W-1:0]  action_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hfp_pkg::IDX_W-1:0]     state_index_o,
  input logic [hfp_pkg::PROB_W-1:0]    alpha_value_o,
  input logic                          last_o
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(state_index_o) && $stable(alpha_value_o) && $stable(last_o)))
    else $error("result changed or dropped while stalled");

  // After an observe transfer, input ready is low in the following cycle.
  a_obs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == hfp_pkg::ACT_OBSERVE) |=> !in_ready_o)
    else $error("input ready right after an observe transfer");

  // After a mid-vector transfer, the next state follows in the next cycle.
  a_vec_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (out_valid_o && state_index_o == hfp_pkg::IDX_W'($past(state_index_o) + 1'b1)))
    else $error("alpha vector not sent in state order");

  // No input is taken while a vector is only partly delivered.
  a_vec_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> !in_ready_o)
    else $error("input ready in the middle of a vector");

endmodule

bind hmm_forward_probability hfp_checker u_hfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .state_index_o (state_index_o),
  .alpha_value_o (alpha_value_o),
  .last_o        (last_o)
);

### verif/tb_hmm_forward_probability.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMM forward probability testbench
// Fills the model tables, then drives an observation without a start, directed
// corner items, three phases of random load and observation traffic with
// varying idle patterns, and an output hold-off. Every emitted alpha vector
// is checked against an internal fixed-point forward-pass predictor.
// ----------------------------------------------------------------------------
module tb_hmm_forward_probability;

  // A cycle count with no transfer on either side that can only mean a hang.
  // The longest legal quiet stretch is the output hold-off below plus one
  // observation walk, well under this.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Receiver hold-off used to back the block up into its input.
  localparam int unsigned HOLD_CYCLES    = 300;
  // Cycles to keep watching after the last expected result, derived from the
  // length of one observation walk so that any late stray result is seen.
  localparam int unsigned DRAIN_CYCLES   =
    2 * (hfp_pkg::NUM_STATES * hfp_pkg::NUM_STATES + 4);

  // One expected result transfer: the alpha of one hidden state.
  typedef struct packed {
    logic [hfp_pkg::IDX_W-1:0]  idx;
    logic [hfp_pkg::PROB_W-1:0] prob;
    logic                       last;
  } alpha_rec_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [hfp_pkg::ACTION_W-1:0] action_i;
  logic [hfp_pkg::IDX_W-1:0]    row_index_i;
  logic [hfp_pkg::IDX_W-1:0]    col_index_i;
  logic [hfp_pkg::PROB_W-1:0]   prob_value_i;
  logic [hfp_pkg::IDX_W-1:0]    obs_symbol_i;
  logic                         seq_start_i;
  logic                         seq_end_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [hfp_pkg::IDX_W-1:0]    state_index_o;
  logic [hfp_pkg::PROB_W-1:0]   alpha_value_o;
  logic                         last_o;

  // Predictor state: our own copy of the tables and the running alpha vector.
  logic [hfp_pkg::PROB_W-1:0] init_tbl  [hfp_pkg::NUM_STATES];
  logic [hfp_pkg::PROB_W-1:0] trans_tbl [hfp_pkg::TRANS_DEPTH];
  logic [hfp_pkg::PROB_W-1:0] emit_tbl  [hfp_pkg::EMIT_DEPTH];
  logic [hfp_pkg::PROB_W-1:0] alpha_vec [hfp_pkg::NUM_STATES];

  // Alpha values still owed by the block, oldest first.
  alpha_rec_t alpha_expect_q [$];

  int unsigned err_cnt;
  // Items that changed predictor state; ignored loads are not counted.
  int unsigned applied_cnt;
  // Percent chance per cycle that each side idles.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // The stimulus bumps hold_req to ask the receiver for one long hold-off.
  int unsigned hold_req;

  hmm_forward_probability u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .prob_value_i  (prob_value_i),
    .obs_symbol_i  (obs_symbol_i),
    .seq_start_i   (seq_start_i),
    .seq_end_i     (seq_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .state_index_o (state_index_o),
    .alpha_value_o (alpha_value_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Q1.31 product: full 64-bit product shifted down by 31, truncating.
  function automatic logic [hfp_pkg::PROB_W-1:0] q_mul(logic [hfp_pkg::PROB_W-1:0] a,
                                                      logic [hfp_pkg::PROB_W-1:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b};
    return p[62:31];
  endfunction

  // An observed symbol beyond the alphabet has zero emission probability.
  function automatic logic [hfp_pkg::PROB_W-1:0] emit_of(int s,
                                                        logic [hfp_pkg::IDX_W-1:0] sym);
    if (sym >= hfp_pkg::NUM_SYMBOLS) return '0;
    return emit_tbl[s * hfp_pkg::NUM_SYMBOLS + sym];
  endfunction

  // Applies one accepted item to the predictor and queues any alpha vector
  // that it causes.
  task automatic forward_step(hfp_pkg::action_e act, logic [hfp_pkg::IDX_W-1:0] row,
                              logic [hfp_pkg::IDX_W-1:0] col,
                              logic [hfp_pkg::PROB_W-1:0] prob,
                              logic [hfp_pkg::IDX_W-1:0] sym, logic st, logic en);
    logic [hfp_pkg::PROB_W-1:0] val;
    logic [hfp_pkg::PROB_W-1:0] nxt [hfp_pkg::NUM_STATES];
    logic [63:0]                acc;
    alpha_rec_t                 rec;
    // Anything above 1.0 is stored as exactly 1.0.
    val = (prob > hfp_pkg::Q_ONE) ? hfp_pkg::Q_ONE : prob;
    case (act)
      hfp_pkg::ACT_LOAD_INIT: begin
        if (row < hfp_pkg::NUM_STATES) begin
          init_tbl[row[hfp_pkg::STATE_W-1:0]] = val;
          applied_cnt++;
        end
      end
      hfp_pkg::ACT_LOAD_TRANS: begin
        if (row < hfp_pkg::NUM_STATES && col < hfp_pkg::NUM_STATES) begin
          trans_tbl[row * hfp_pkg::NUM_STATES + col] = val;
          applied_cnt++;
        end
      end
      hfp_pkg::ACT_LOAD_EMIT: begin
        if (row < hfp_pkg::NUM_STATES && col < hfp_pkg::NUM_SYMBOLS) begin
          emit_tbl[row * hfp_pkg::NUM_SYMBOLS + col] = val;
          applied_cnt++;
        end
      end
      default: begin
        applied_cnt++;
        if (st) begin
          for (int i = 0; i < hfp_pkg::NUM_STATES; i++)
            alpha_vec[i] = q_mul(init_tbl[i], emit_of(i, sym));
        end else begin
          // Each destination sums its truncated incoming products, clipping
          // at 1.0 after every addition, then weights by its emission.
          for (int j = 0; j < hfp_pkg::NUM_STATES; j++) begin
            acc = '0;
            for (int i = 0; i < hfp_pkg::NUM_STATES; i++) begin
              acc = acc + 64'(q_mul(alpha_vec[i], trans_tbl[i * hfp_pkg::NUM_STATES + j]));
              if (acc > 64'(hfp_pkg::Q_ONE)) acc = 64'(hfp_pkg::Q_ONE);
            end
            nxt[j] = q_mul(acc[hfp_pkg::PROB_W-1:0], emit_of(j, sym));
          end
          alpha_vec = nxt;
        end
        if (en) begin
          for (int i = 0; i < hfp_pkg::NUM_STATES; i++) begin
            rec = '{idx: i[hfp_pkg::IDX_W-1:0], prob: alpha_vec[i],
                    last: (i == hfp_pkg::NUM_STATES - 1)};
            alpha_expect_q = {alpha_expect_q, rec};
          end
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one item after a random idle gap and holds it until the block takes
  // it. Valid is left high on return so that a back-to-back item never lowers
  // and raises it in the same step; the next call or the end of the stimulus
  // decides what it does next.
  task automatic send_item(hfp_pkg::action_e act, logic [hfp_pkg::IDX_W-1:0] row,
                           logic [hfp_pkg::IDX_W-1:0] col,
                           logic [hfp_pkg::PROB_W-1:0] prob,
                           logic [hfp_pkg::IDX_W-1:0] sym, logic st, logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    row_index_i  <= row;
    col_index_i  <= col;
    prob_value_i <= prob;
    obs_symbol_i <= sym;
    seq_start_i  <= st;
    seq_end_i    <= en;
    @(posedge clk_i);
    // Ready is sampled as it stood just before this edge.
    while (!in_ready_o) @(posedge clk_i);
    forward_step(act, row, col, prob, sym, st, en);
  endtask

  // Loads carry random observation fields, which the block must ignore.
  task automatic send_load(hfp_pkg::action_e act, logic [hfp_pkg::IDX_W-1:0] row,
                           logic [hfp_pkg::IDX_W-1:0] col,
                           logic [hfp_pkg::PROB_W-1:0] prob);
    logic [hfp_pkg::IDX_W-1:0] sym;
    logic [1:0]                flags;
    sym   = hfp_pkg::IDX_W'($urandom());
    flags = 2'($urandom());
    send_item(act, row, col, prob, sym, flags[0], flags[1]);
  endtask

  // Observations carry random load fields, which the block must ignore.
  task automatic send_observe(logic [hfp_pkg::IDX_W-1:0] sym, logic st, logic en);
    logic [hfp_pkg::IDX_W-1:0]  row;
    logic [hfp_pkg::IDX_W-1:0]  col;
    logic [hfp_pkg::PROB_W-1:0] prob;
    row  = hfp_pkg::IDX_W'($urandom());
    col  = hfp_pkg::IDX_W'($urandom());
    prob = $urandom();
    send_item(hfp_pkg::ACT_OBSERVE, row, col, prob, sym, st, en);
  endtask

  // Probabilities lean toward the upper half so that alphas do not all decay
  // to zero within a couple of steps; some raw words exceed 1.0 on purpose.
  function automatic logic [hfp_pkg::PROB_W-1:0] rand_prob();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return hfp_pkg::Q_ONE;
    if (pick < 14) return '0;
    if (pick < 22) return $urandom();
    if (pick < 60) return $urandom_range(hfp_pkg::Q_ONE, hfp_pkg::Q_ONE / 2);
    return $urandom_range(hfp_pkg::Q_ONE, 0);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random ready, optional long hold-off, and the result check
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("ERROR: %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_alpha();
    alpha_rec_t exp_r;
    if (alpha_expect_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result state %0d alpha %08h last %0b",
                                state_index_o, alpha_value_o, last_o));
    end else begin
      exp_r = alpha_expect_q.pop_front();
      if (state_index_o !== exp_r.idx)
        report_mismatch($sformatf("state_index expected %0d got %0d",
                                  exp_r.idx, state_index_o));
      if (alpha_value_o !== exp_r.prob)
        report_mismatch($sformatf("alpha_value of state %0d expected %08h got %08h",
                                  exp_r.idx, exp_r.prob, alpha_value_o));
      if (last_o !== exp_r.last)
        report_mismatch($sformatf("last of state %0d expected %0b got %0b",
                                  exp_r.idx, exp_r.last, last_o));
    end
  endtask

  initial begin : receiver
    int unsigned hold_ack;
    int unsigned hold_left;
    hold_ack    = 0;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      // Both signals hold their pre-edge values here, so this is exactly the
      // set of edges at which a result transfer happens.
      if (out_valid_o && out_ready_i) check_alpha();
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_ack) begin
        hold_ack    = hold_req;
        hold_left   = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run if neither side completes a transfer for too long, which
  // also catches results that never arrive.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every table entry is written before any observation, since the block's
  // tables hold nothing meaningful until loaded.
  task automatic test_fill_tables();
    for (int i = 0; i < hfp_pkg::NUM_STATES; i++)
      send_load(hfp_pkg::ACT_LOAD_INIT, hfp_pkg::IDX_W'(i), hfp_pkg::IDX_W'($urandom()),
                rand_prob());
    for (int i = 0; i < hfp_pkg::NUM_STATES; i++)
      for (int j = 0; j < hfp_pkg::NUM_STATES; j++)
        send_load(hfp_pkg::ACT_LOAD_TRANS, hfp_pkg::IDX_W'(i), hfp_pkg::IDX_W'(j),
                  rand_prob());
    for (int i = 0; i < hfp_pkg::NUM_STATES; i++)
      for (int s = 0; s < hfp_pkg::NUM_SYMBOLS; s++)
        send_load(hfp_pkg::ACT_LOAD_EMIT, hfp_pkg::IDX_W'(i), hfp_pkg::IDX_W'(s),
                  rand_prob());
  endtask

  // The first observation of the run has no start, so it must recurse from
  // the all-zero alpha vector left by reset and emit zeros.
  task automatic test_observe_without_start();
    send_observe(hfp_pkg::IDX_W'($urandom_range(hfp_pkg::NUM_SYMBOLS - 1)), 1'b0, 1'b1);
  endtask

  task automatic test_directed_corners();
    // Initial probabilities at and beyond 1.0; words above 1.0 are stored
    // as 1.0.
    send_load(hfp_pkg::ACT_LOAD_INIT, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_load(hfp_pkg::ACT_LOAD_INIT, 4'd1, 4'd0, hfp_pkg::Q_ONE);
    send_load(hfp_pkg::ACT_LOAD_INIT, 4'd2, 4'd0, 32'h8000_0001);
    send_load(hfp_pkg::ACT_LOAD_INIT, hfp_pkg::IDX_W'(hfp_pkg::NUM_STATES - 1), 4'd0,
              hfp_pkg::Q_ONE);
    // Symbol 0 is certain in every state, so each alpha starts at 1.0.
    for (int i = 0; i < hfp_pkg::NUM_STATES; i++)
      send_load(hfp_pkg::ACT_LOAD_EMIT, hfp_pkg::IDX_W'(i), 4'd0, hfp_pkg::Q_ONE);
    // Two certain transitions into state 0 push its sum past 1.0.
    send_load(hfp_pkg::ACT_LOAD_TRANS, 4'd0, 4'd0, hfp_pkg::Q_ONE);
    send_load(hfp_pkg::ACT_LOAD_TRANS, 4'd1, 4'd0, hfp_pkg::Q_ONE);
    // A zero probability.
    send_load(hfp_pkg::ACT_LOAD_EMIT, hfp_pkg::IDX_W'(hfp_pkg::NUM_STATES - 1), 4'd1, '0);
    // Loads addressed beyond their table are dropped and must not disturb
    // the entries above.
    send_load(hfp_pkg::ACT_LOAD_INIT, hfp_pkg::IDX_W'(hfp_pkg::NUM_STATES), 4'd0, '0);
    send_load(hfp_pkg::ACT_LOAD_INIT, 4'hF, 4'hF, '0);
    send_load(hfp_pkg::ACT_LOAD_TRANS, 4'hF, 4'd0, '0);
    send_load(hfp_pkg::ACT_LOAD_TRANS, 4'd0, 4'hF, '0);
    send_load(hfp_pkg::ACT_LOAD_EMIT, 4'h8, hfp_pkg::IDX_W'(hfp_pkg::NUM_SYMBOLS - 1), '0);
    send_load(hfp_pkg::ACT_LOAD_EMIT, 4'd2, hfp_pkg::IDX_W'(hfp_pkg::NUM_SYMBOLS), '0);
    // Start and end on one item: initialized and emitted at once.
    send_observe(4'd0, 1'b1, 1'b1);
    // A two-step sequence whose second step saturates state 0.
    send_observe(4'd0, 1'b1, 1'b0);
    send_observe(4'd0, 1'b0, 1'b1);
    // Symbols beyond the alphabet zero the alphas they touch, on a start and
    // on a continuation.
    send_observe(4'hF, 1'b1, 1'b1);
    send_observe(hfp_pkg::IDX_W'(hfp_pkg::NUM_SYMBOLS), 1'b0, 1'b1);
  endtask

  // Mostly well-formed sequences (optional table updates, a start, zero to
  // three continuations, an end), with the rest fully random items that
  // cover stray starts and ends, out-of-range indexes and every field bit.
  task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct,
                                     int unsigned n_items);
    int unsigned                target;
    int unsigned                n_obs;
    hfp_pkg::action_e           act;
    logic [hfp_pkg::IDX_W-1:0]  row;
    logic [hfp_pkg::IDX_W-1:0]  col;
    logic [hfp_pkg::IDX_W-1:0]  sym;
    logic [hfp_pkg::PROB_W-1:0] prob;
    logic [1:0]                 flags;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target        = applied_cnt + n_items;
    while (applied_cnt < target) begin
      if ($urandom_range(9) < 7) begin
        repeat ($urandom_range(2)) begin
          act = hfp_pkg::action_e'($urandom_range(hfp_pkg::ACT_LOAD_EMIT));
          row = hfp_pkg::IDX_W'($urandom_range(hfp_pkg::NUM_STATES - 1));
          col = (act == hfp_pkg::ACT_LOAD_EMIT)
              ? hfp_pkg::IDX_W'($urandom_range(hfp_pkg::NUM_SYMBOLS - 1))
              : hfp_pkg::IDX_W'($urandom_range(hfp_pkg::NUM_STATES - 1));
          send_load(act, row, col, rand_prob());
        end
        n_obs = $urandom_range(4, 1);
        for (int k = 0; k < n_obs; k++) begin
          sym = ($urandom_range(9) == 0)
              ? hfp_pkg::IDX_W'($urandom_range(15, hfp_pkg::NUM_SYMBOLS))
              : hfp_pkg::IDX_W'($urandom_range(hfp_pkg::NUM_SYMBOLS - 1));
          send_observe(sym, k == 0, k == n_obs - 1);
        end
      end else begin
        act   = hfp_pkg::action_e'($urandom_range(hfp_pkg::ACT_OBSERVE));
        row   = hfp_pkg::IDX_W'($urandom());
        col   = hfp_pkg::IDX_W'($urandom());
        prob  = $urandom();
        sym   = hfp_pkg::IDX_W'($urandom());
        flags = 2'($urandom());
        send_item(act, row, col, prob, sym, flags[0], flags[1]);
      end
    end
  endtask

  // The receiver stops for a long stretch while the sender streams complete
  // vectors with no gaps, so the block's output fills and it has to stall
  // its input until the receiver resumes.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    repeat (8)
      send_observe(hfp_pkg::IDX_W'($urandom_range(hfp_pkg::NUM_SYMBOLS - 1)), 1'b1, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------

  initial begin
    err_cnt       = 0;
    applied_cnt   = 0;
    hold_req      = 0;
    send_idle_pct = 36;
    recv_idle_pct = 46;
    for (int i = 0; i < hfp_pkg::NUM_STATES; i++) alpha_vec[i] = '0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= hfp_pkg::ACT_LOAD_INIT;
    row_index_i  <= '0;
    col_index_i  <= '0;
    prob_value_i <= '0;
    obs_symbol_i <= '0;
    seq_start_i  <= 1'b0;
    seq_end_i    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_tables();
    test_observe_without_start();
    test_directed_corners();
    test_random_traffic(36, 46, 18);
    test_random_traffic(46, 36, 18);
    test_random_traffic(0, 0, 18);
    test_output_backpressure();
    in_valid_i <= 1'b0;

    // Let every owed result drain, then watch a little longer for strays.
    while (alpha_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### hmm_forward_probability.f
hdl/hfp_pkg.sv
hdl/hfp_ctrl.sv
hdl/hfp_dp.sv
hdl/hmm_forward_probability.sv
hdl/hfp_checker.sv
verif/tb_hmm_forward_probability.sv
